FILE: sv/fmg_pkg.sv
package fmg_pkg;

  localparam int DEGREE_W   = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_INDEX_W = 3;

  typedef logic [MODE_W-1:0]      shape_mode_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam shape_mode_t MODE_FALL = 2'd0;
  localparam shape_mode_t MODE_RISE = 2'd1;
  localparam shape_mode_t MODE_TRAP = 2'd2;
  localparam shape_mode_t MODE_RESET = MODE_TRAP;

  localparam cfg_index_t CFG_SHAPE_MODE = 3'd0;
  localparam cfg_index_t CFG_BREAK_A    = 3'd1;
  localparam cfg_index_t CFG_BREAK_B    = 3'd2;
  localparam cfg_index_t CFG_BREAK_C    = 3'd3;
  localparam cfg_index_t CFG_BREAK_D    = 3'd4;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_RAMP,
    KIND_DIV
  } grade_kind_t;

endpackage

FILE: sv/fuzzy_membership_grade_unit.sv
// Trapezoidal fuzzifier: maps a signed crisp sample to a membership degree with
// FRACTION_BITS fraction bits (1 << FRACTION_BITS is 1.0), shown on 16 bits.
// Channels: in_* carries one crisp sample per transaction, out_* one degree per
// transaction, both with valid/ready. cfg_* writes shape_mode (index 0) and the
// breakpoints break_a..break_d (indexes 1..4); cfg_ready is always high. The user
// must make writes only while the block is idle; the block does not enforce this.
// Pipeline: one stage compares the sample with the breakpoints, one resolves the
// ramp, FRACTION_BITS stages each produce one quotient bit of the restoring
// divider, and one output register follows.
// Throughput: one transaction per cycle while the output is not stalled; every
// divider step has a stage of its own, so a sample can enter each cycle.
// Reset: the pipeline empties and the registers return to trapezoid shape with
// all breakpoints at zero.
// Stall: when out_ready is low the result holds in the output register and
// earlier stages keep filling empty slots; in_ready drops only once every
// stage is occupied. Nothing is lost or repeated.
module fuzzy_membership_grade_unit #(
  parameter int VALUE_WIDTH   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [VALUE_WIDTH-1:0]       in_crisp_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fmg_pkg::DEGREE_W-1:0]        out_degree,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fmg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [VALUE_WIDTH-1:0]              cfg_data
);
  import fmg_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int NS = F + 2;
  localparam logic signed [W:0] ZERO_V = '0;

  shape_mode_t            shape_r;
  logic signed [W-1:0]    break_a_r;
  logic signed [W-1:0]    break_b_r;
  logic signed [W-1:0]    break_c_r;
  logic signed [W-1:0]    break_d_r;

  logic [NS-1:0]          v_r;
  logic [NS:0]            mv;
  grade_kind_t            kind_r [0:NS-1];
  logic signed [W:0]      num0_r;
  logic signed [W:0]      den0_r;
  logic [W-1:0]           rem_r [1:NS-1];
  logic [W-1:0]           den_r [1:NS-1];
  logic [F-1:0]           q_r   [1:NS-1];

  logic                   out_valid_r;
  logic [DEGREE_W-1:0]    out_degree_r;

  grade_kind_t            kind0_nxt;
  logic signed [W:0]      num0_nxt;
  logic signed [W:0]      den0_nxt;
  logic signed [W:0]      xe, ae, be, ce, de;
  grade_kind_t            kind1_nxt;
  logic [F+DEGREE_W:0]    grade_w;
  logic [DEGREE_W-1:0]    out_degree_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r   <= MODE_RESET;
      break_a_r <= '0;
      break_b_r <= '0;
      break_c_r <= '0;
      break_d_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SHAPE_MODE: shape_r   <= cfg_data[MODE_W-1:0];
        CFG_BREAK_A:    break_a_r <= cfg_data;
        CFG_BREAK_B:    break_b_r <= cfg_data;
        CFG_BREAK_C:    break_c_r <= cfg_data;
        CFG_BREAK_D:    break_d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its content moves on
  assign mv[NS] = !out_valid_r || out_ready;
  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_mv
      assign mv[g] = !v_r[g] || mv[g+1];
    end
  endgenerate
  assign in_ready = mv[0];

  // stage 0: place the sample against the breakpoints
  always_comb begin
    xe = {in_crisp_value[W-1], in_crisp_value};
    ae = {break_a_r[W-1], break_a_r};
    be = {break_b_r[W-1], break_b_r};
    ce = {break_c_r[W-1], break_c_r};
    de = {break_d_r[W-1], break_d_r};
    kind0_nxt = KIND_ZERO;
    num0_nxt  = ZERO_V;
    den0_nxt  = ZERO_V;
    case (shape_r)
      MODE_FALL: begin
        if (xe <= ae) begin
          kind0_nxt = KIND_ONE;
        end else if (xe > be) begin
          kind0_nxt = KIND_ZERO;
        end else begin
          kind0_nxt = KIND_RAMP;
          num0_nxt  = be - xe;
          den0_nxt  = be - ae;
        end
      end
      MODE_RISE: begin
        if (xe <= ae) begin
          kind0_nxt = KIND_ZERO;
        end else if (xe > be) begin
          kind0_nxt = KIND_ONE;
        end else begin
          kind0_nxt = KIND_RAMP;
          num0_nxt  = xe - ae;
          den0_nxt  = be - ae;
        end
      end
      MODE_TRAP: begin
        if (xe <= ae || xe >= de) begin
          kind0_nxt = KIND_ZERO;
        end else if (xe >= be && xe <= ce) begin
          kind0_nxt = KIND_ONE;
        end else if (xe < be) begin
          kind0_nxt = KIND_RAMP;
          num0_nxt  = xe - ae;
          den0_nxt  = be - ae;
        end else begin
          kind0_nxt = KIND_RAMP;
          num0_nxt  = de - xe;
          den0_nxt  = de - ce;
        end
      end
      default: kind0_nxt = KIND_ZERO;
    endcase
  end

  // stage 1: guard the divisor and saturate
  always_comb begin
    kind1_nxt = kind_r[0];
    if (kind_r[0] == KIND_RAMP) begin
      if (num0_r <= ZERO_V || den0_r <= ZERO_V) begin
        kind1_nxt = KIND_ZERO;
      end else if (num0_r >= den0_r) begin
        kind1_nxt = KIND_ONE;
      end else begin
        kind1_nxt = KIND_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
      v_r[1] <= 1'b0;
    end else begin
      if (mv[0]) v_r[0] <= in_valid;
      if (mv[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (mv[0]) begin
      kind_r[0] <= kind0_nxt;
      num0_r    <= num0_nxt;
      den0_r    <= den0_nxt;
    end
    if (mv[1]) begin
      kind_r[1] <= kind1_nxt;
      rem_r[1]  <= num0_r[W-1:0];
      den_r[1]  <= den0_r[W-1:0];
      q_r[1]    <= '0;
    end
  end

  // stages 2 .. F+1: one restoring division step each
  generate
    for (g = 2; g < NS; g++) begin : g_div
      logic [W:0]   trial;
      logic [W:0]   diff;
      logic         ge;
      logic [W-1:0] rem_nxt;
      logic [F-1:0] q_nxt;

      assign trial   = {rem_r[g-1], 1'b0};
      assign diff    = trial - {1'b0, den_r[g-1]};
      assign ge      = trial >= {1'b0, den_r[g-1]};
      assign rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      assign q_nxt   = {q_r[g-1][F-2:0], ge};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else if (mv[g]) begin
          v_r[g] <= v_r[g-1];
        end
      end

      always_ff @(posedge clk) begin
        if (mv[g]) begin
          kind_r[g] <= kind_r[g-1];
          rem_r[g]  <= rem_nxt;
          den_r[g]  <= den_r[g-1];
          q_r[g]    <= q_nxt;
        end
      end
    end
  endgenerate

  always_comb begin
    grade_w = '0;
    case (kind_r[NS-1])
      KIND_ONE: grade_w[F]     = 1'b1;
      KIND_DIV: grade_w[F-1:0] = q_r[NS-1];
      default:  grade_w        = '0;
    endcase
    out_degree_nxt = grade_w[DEGREE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mv[NS]) begin
      out_valid_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (mv[NS]) begin
      out_degree_r <= out_degree_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_degree = out_degree_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty output register");

  a_ramp_resolved: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> kind_r[1] != KIND_RAMP)
    else $error("unresolved ramp left the guard stage");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && kind_r[1] == KIND_DIV) |-> (rem_r[1] < den_r[1] && den_r[1] != '0))
    else $error("divider entered with numerator not below divisor");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && kind_r[NS-1] == KIND_DIV) |-> rem_r[NS-1] < den_r[NS-1])
    else $error("divider remainder out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && $countones(v_r) == NS) |-> !in_ready)
    else $error("input accepted into a full pipeline");

endmodule

FILE: tb/fuzzy_membership_grade_checker.sv
`timescale 1ns / 1ps
module fuzzy_membership_grade_checker #(
  parameter int VALUE_WIDTH   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [VALUE_WIDTH-1:0]        in_crisp_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [fmg_pkg::DEGREE_W-1:0]  out_degree,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  fmg_pkg::cfg_index_t           cfg_index,
  input  logic [VALUE_WIDTH-1:0]        cfg_data,
  output int                            fail_count,
  output int                            degrees_in_flight
);
  import fmg_pkg::*;

  localparam longint UNITY = longint'(1) << FRACTION_BITS;

  shape_mode_t                   shape = MODE_RESET;
  logic signed [VALUE_WIDTH-1:0] bp_a = '0;
  logic signed [VALUE_WIDTH-1:0] bp_b = '0;
  logic signed [VALUE_WIDTH-1:0] bp_c = '0;
  logic signed [VALUE_WIDTH-1:0] bp_d = '0;
  logic [DEGREE_W-1:0]           pending_degrees[$];
  int                            fails = 0;

  function automatic longint ramp_fraction(input longint num, input longint den);
    longint q;
    if (den <= 0 || num <= 0) return 0;
    q = (num << FRACTION_BITS) / den;
    return (q > UNITY) ? UNITY : q;
  endfunction

  function automatic logic [DEGREE_W-1:0] membership_degree(
    input logic signed [VALUE_WIDTH-1:0] sample
  );
    longint x, x0, x1, x2, x3, g;
    x  = sample;
    x0 = bp_a;
    x1 = bp_b;
    x2 = bp_c;
    x3 = bp_d;
    case (shape)
      MODE_FALL: begin
        if (x <= x0) g = UNITY;
        else if (x > x1) g = 0;
        else g = ramp_fraction(x1 - x, x1 - x0);
      end
      MODE_RISE: begin
        if (x <= x0) g = 0;
        else if (x > x1) g = UNITY;
        else g = ramp_fraction(x - x0, x1 - x0);
      end
      MODE_TRAP: begin
        if (x <= x0 || x >= x3) g = 0;
        else if (x >= x1 && x <= x2) g = UNITY;
        else if (x < x1) g = ramp_fraction(x - x0, x1 - x0);
        else g = ramp_fraction(x3 - x, x3 - x2);
      end
      default: g = 0;
    endcase
    return g[DEGREE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [DEGREE_W-1:0] want;
    if (!rst_n) begin
      shape <= MODE_RESET;
      bp_a  <= '0;
      bp_b  <= '0;
      bp_c  <= '0;
      bp_d  <= '0;
      pending_degrees.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHAPE_MODE: shape <= cfg_data[MODE_W-1:0];
          CFG_BREAK_A:    bp_a  <= cfg_data;
          CFG_BREAK_B:    bp_b  <= cfg_data;
          CFG_BREAK_C:    bp_c  <= cfg_data;
          CFG_BREAK_D:    bp_d  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_degrees.push_back(membership_degree(in_crisp_value));
      end
      if (out_valid && out_ready) begin
        if (pending_degrees.size() == 0) begin
          $error("degree: unexpected transaction, expected none, actual %0d", out_degree);
          fails++;
        end else begin
          want = pending_degrees.pop_front();
          if (out_degree !== want) begin
            $error("degree mismatch: expected %0d, actual %0d", want, out_degree);
            fails++;
          end
        end
      end
    end
    fail_count        <= fails;
    degrees_in_flight <= pending_degrees.size();
  end

endmodule

FILE: tb/fuzzy_membership_grade_unit_tb.sv
`timescale 1ns / 1ps
module fuzzy_membership_grade_unit_tb;
  import fmg_pkg::*;

  localparam int VALUE_WIDTH   = 16;
  localparam int FRACTION_BITS = 15;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int VMIN          = -32768;
  localparam int VMAX          = 32767;

  localparam shape_mode_t MODE_UNUSED  = 2'd3;
  localparam cfg_index_t  CFG_SPARE_LO = 3'd5;
  localparam cfg_index_t  CFG_SPARE_HI = 3'd7;

  logic                   clk            = 1'b0;
  logic                   rst_n          = 1'b0;
  logic                   in_valid       = 1'b0;
  logic [VALUE_WIDTH-1:0] in_crisp_value = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   out_ready      = 1'b0;
  logic [DEGREE_W-1:0]    out_degree;
  logic                   cfg_valid      = 1'b0;
  logic                   cfg_ready;
  cfg_index_t             cfg_index      = CFG_SHAPE_MODE;
  logic [VALUE_WIDTH-1:0] cfg_data       = '0;

  int fail_count;
  int degrees_in_flight;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int bp[4]          = '{0, 0, 0, 0};

  always #5 clk = ~clk;

  fuzzy_membership_grade_unit #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_crisp_value(in_crisp_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_degree    (out_degree),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  fuzzy_membership_grade_checker #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_crisp_value   (in_crisp_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_degree       (out_degree),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .degrees_in_flight(degrees_in_flight)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int sat16(input int v);
    return (v < VMIN) ? VMIN : (v > VMAX) ? VMAX : v;
  endfunction

  task automatic send_sample(input int x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_crisp_value <= 16'(x);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_all_degrees();
    in_valid <= 1'b0;
    @(posedge clk);
    while (degrees_in_flight != 0) @(posedge clk);
  endtask

  task automatic program_shape(input logic [VALUE_WIDTH-1:0] mode_word,
                               input int a, input int b, input int c, input int d);
    logic [VALUE_WIDTH-1:0] words[5];
    cfg_index_t             regs[5];
    words = '{mode_word, 16'(a), 16'(b), 16'(c), 16'(d)};
    regs  = '{CFG_SHAPE_MODE, CFG_BREAK_A, CFG_BREAK_B, CFG_BREAK_C, CFG_BREAK_D};
    bp    = '{a, b, c, d};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= words[i];
      do @(posedge clk); while (!cfg_ready);
    end
    // spare index: must leave every register untouched
    cfg_index <= cfg_index_t'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO));
    cfg_data  <= 16'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_shape();
    int                     v[4];
    int                     center, style, pick, t;
    shape_mode_t            m;
    logic [VALUE_WIDTH-1:0] mode_word;
    style  = $urandom_range(9);
    center = int'($urandom_range(65535)) - 32768;
    for (int i = 0; i < 4; i++) begin
      if (style <= 5) begin
        v[i] = sat16(center + int'($urandom_range(600)) - 300);
      end else if (style == 8) begin
        pick = $urandom_range(2);
        v[i] = (pick == 0) ? VMIN : (pick == 1) ? 0 : VMAX;
      end else begin
        v[i] = int'($urandom_range(65535)) - 32768;
      end
    end
    // keep breakpoints ordered except for the scrambled style
    if (style != 9) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3 - i; j++) begin
          if (v[j] > v[j+1]) begin
            t      = v[j];
            v[j]   = v[j+1];
            v[j+1] = t;
          end
        end
      end
    end
    pick = $urandom_range(15);
    m = (pick < 5) ? MODE_FALL : (pick < 10) ? MODE_RISE :
        (pick < 15) ? MODE_TRAP : MODE_UNUSED;
    mode_word = 16'($urandom);
    mode_word[MODE_W-1:0] = m;
    program_shape(mode_word, v[0], v[1], v[2], v[3]);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] random_sample();
    int lo, hi, sel;
    lo = bp[0];
    hi = bp[0];
    foreach (bp[i]) begin
      if (bp[i] < lo) lo = bp[i];
      if (bp[i] > hi) hi = bp[i];
    end
    lo  = sat16(lo - 50);
    hi  = sat16(hi + 50);
    sel = $urandom_range(9);
    if (sel <= 5) return 16'(lo + int'($urandom_range(hi - lo)));
    if (sel <= 7) return 16'(sat16(bp[$urandom_range(3)] + int'($urandom_range(4)) - 2));
    return 16'($urandom);
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset shape: trapezoid with every breakpoint at zero
    send_sample(0);
    send_sample(VMAX);
    send_sample(VMIN);
    wait_all_degrees();

    program_shape({14'h3FFF, MODE_FALL}, -100, 100, 0, 0);
    send_sample(VMIN);
    send_sample(-100);
    send_sample(-99);
    send_sample(0);
    send_sample(100);
    send_sample(101);
    send_sample(VMAX);
    wait_all_degrees();

    program_shape({14'h0000, MODE_RISE}, VMIN, VMAX, VMAX, VMIN);
    send_sample(VMIN);
    send_sample(VMIN + 1);
    send_sample(0);
    send_sample(VMAX);
    wait_all_degrees();

    program_shape({14'h1555, MODE_TRAP}, -1000, -10, 10, 1000);
    send_sample(-1000);
    send_sample(-999);
    send_sample(-10);
    send_sample(0);
    send_sample(10);
    send_sample(999);
    send_sample(1000);
    wait_all_degrees();

    // unordered breakpoints
    program_shape({14'h2AAA, MODE_TRAP}, 0, -50, -100, 200);
    send_sample(10);
    send_sample(150);
    wait_all_degrees();

    program_shape({14'h0F0F, MODE_UNUSED}, 5, 10, 20, 30);
    send_sample(15);
    wait_all_degrees();

    // zero-width ramp
    program_shape({14'h3000, MODE_FALL}, 50, 50, 50, 50);
    send_sample(50);
    send_sample(51);
    wait_all_degrees();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
        end
      endcase
      repeat (6) begin
        random_shape();
        repeat (25) send_sample(int'(random_sample()));
        wait_all_degrees();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && degrees_in_flight == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/fmg_pkg.sv
sv/fuzzy_membership_grade_unit.sv
tb/fuzzy_membership_grade_checker.sv
tb/fuzzy_membership_grade_unit_tb.sv
